/* rtl/fsmf_pkg.sv */
// Package for the first substring match finder: result word type,
// configuration register codes and default sizes. No dependencies.
`default_nettype none

package fsmf_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int INDEX_BITS_DEF        = 16;
  localparam int PATTERN_SLOTS         = 16;
  localparam int SUM_W                 = 12;
  localparam int MATCH_INDEX_W         = 16;
  localparam int CFG_DATA_W            = 64;
  localparam int CFG_LEN_W             = 5;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                     found;
    logic [MATCH_INDEX_W-1:0] match_index;
    logic                     position_saturated;
  } res_t;

endpackage

`default_nettype wire

/* rtl/first_substring_match_finder.sv */
// First substring match finder: top level with window, rolling sum, compare
// and a two-word output buffer. Depends on fsmf_pkg.
//
// Usage: text bytes enter on the in_ channel (valid/ready), in_final_byte set
// on the last byte of a text. One result word per text leaves on the out_
// channel: found with the start index of the first exact match, sent on the
// byte that completes it, or not found on the final byte. Bytes after a match
// are consumed without a result until the final byte.
// Throughput: one byte per cycle while in_ready is high; the whole window
// compare is one registered pass from the state registers and the incoming
// byte to the output register, or to the skid register while the output
// register holds a word that is not taken.
// Stall: an output register and a skid register hold up to two results;
// in_ready drops while the skid register holds a word, from the cycle after a
// result meets a full output register with out_ready low.
// Reset: synchronous, active low; clears the pattern, per-text state and the
// output buffer. A pattern write through cfg_ also aborts the text in progress.
`default_nettype none

module first_substring_match_finder #(
  parameter int MAX_PATTERN_BYTES = fsmf_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int INDEX_BITS        = fsmf_pkg::INDEX_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [fsmf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         in_text_byte,
  input  wire logic                               in_final_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_found,
  output logic [fsmf_pkg::MATCH_INDEX_W-1:0]      out_match_index,
  output logic                                    out_position_saturated
);

  import fsmf_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int WIDE_W = (INDEX_BITS > MATCH_INDEX_W) ? INDEX_BITS : MATCH_INDEX_W;

  logic [CFG_DATA_W-1:0]   pat_lo_r;
  logic [CFG_DATA_W-1:0]   pat_hi_r;
  logic [CFG_LEN_W-1:0]    pat_len_r;

  logic [7:0]              win_r [MAX_PATTERN_BYTES];
  logic [SUM_W-1:0]        win_sum_r;
  logic [INDEX_BITS-1:0]   pos_r;
  logic                    ovf_r;
  logic                    sent_r;

  logic                    out_v_r, sk_v_r;
  res_t                    out_d_r, sk_d_r;
  logic                    out_v_nxt, sk_v_nxt;
  res_t                    out_d_nxt, sk_d_nxt;

  logic                    cfg_clear;
  logic                    in_acc, pop, push;
  logic [LEN_W-1:0]        len_u;
  logic [7:0]              pat_b   [PATTERN_SLOTS];
  logic [7:0]              win_new [MAX_PATTERN_BYTES];
  logic [SUM_W-1:0]        lvl0 [16];
  logic [SUM_W-1:0]        lvl1 [8];
  logic [SUM_W-1:0]        lvl2 [4];
  logic [SUM_W-1:0]        lvl3 [2];
  logic [SUM_W-1:0]        pat_sum;
  logic [7:0]              old_byte;
  logic                    drop, armed, eq, hit;
  logic [3:0]              pidx [MAX_PATTERN_BYTES];
  logic [SUM_W-1:0]        sum_nxt;
  logic [INDEX_BITS-1:0]   len_ix, start;
  logic [WIDE_W-1:0]       start_wide;
  res_t                    res;

  assign cfg_clear = cfg_we && (cfg_index == REG_PATTERN_LOW || cfg_index == REG_PATTERN_HIGH
                                || cfg_index == REG_PATTERN_LEN);
  assign in_ready  = !sk_v_r;
  assign in_acc    = in_valid && in_ready;
  assign pop       = out_v_r && out_ready;

  always_comb begin
    if (pat_len_r > CFG_LEN_W'(MAX_PATTERN_BYTES)) len_u = LEN_W'(MAX_PATTERN_BYTES);
    else len_u = pat_len_r[LEN_W-1:0];
    len_ix = INDEX_BITS'(len_u);
    for (int k = 0; k < PATTERN_SLOTS; k++) begin
      pat_b[k] = (k < 8) ? pat_lo_r[8*(k%8) +: 8] : pat_hi_r[8*(k%8) +: 8];
      lvl0[k]  = (k < int'(len_u)) ? SUM_W'(pat_b[k]) : '0;
    end
    for (int k = 0; k < 8; k++) lvl1[k] = lvl0[2*k] + lvl0[2*k+1];
    for (int k = 0; k < 4; k++) lvl2[k] = lvl1[2*k] + lvl1[2*k+1];
    for (int k = 0; k < 2; k++) lvl3[k] = lvl2[2*k] + lvl2[2*k+1];
    pat_sum = lvl3[0] + lvl3[1];
  end

  always_comb begin
    old_byte = '0;
    eq       = 1'b1;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      win_new[j] = (j == 0) ? in_text_byte : win_r[(j == 0) ? 0 : j-1];
      pidx[j]    = 4'(int'(len_u) - 1 - j);
      if (j == int'(len_u) - 1) old_byte = old_byte | win_r[j];
      if (j < int'(len_u) && win_new[j] != pat_b[pidx[j]]) eq = 1'b0;
    end
    drop    = (len_u != '0) && (ovf_r || pos_r >= len_ix);
    sum_nxt = win_sum_r - (drop ? SUM_W'(old_byte) : SUM_W'(0)) + SUM_W'(in_text_byte);
    armed   = ovf_r || (pos_r >= len_ix - INDEX_BITS'(1));
    if (len_u == '0) begin
      hit   = 1'b1;
      start = '0;
    end else begin
      hit   = armed && (sum_nxt == pat_sum) && eq;
      start = ovf_r ? '1 : (pos_r - (len_ix - INDEX_BITS'(1)));
    end
    start_wide             = WIDE_W'(start);
    res.found              = hit;
    res.match_index        = hit ? start_wide[MATCH_INDEX_W-1:0] : '0;
    res.position_saturated = ovf_r;
    push = in_acc && !sent_r && (hit || in_final_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pat_lo_r  <= cfg_data;
        REG_PATTERN_HIGH: pat_hi_r  <= cfg_data;
        REG_PATTERN_LEN:  pat_len_r <= cfg_data[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !sent_r && !cfg_clear) begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) win_r[j] <= win_new[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      win_sum_r <= '0;
      pos_r     <= '0;
      ovf_r     <= 1'b0;
      sent_r    <= 1'b0;
    end else if (in_acc) begin
      if (in_final_byte) begin
        win_sum_r <= '0;
        pos_r     <= '0;
        ovf_r     <= 1'b0;
        sent_r    <= 1'b0;
      end else if (!sent_r) begin
        win_sum_r <= sum_nxt;
        sent_r    <= hit;
        if (pos_r == '1) ovf_r <= 1'b1;
        else pos_r <= pos_r + INDEX_BITS'(1);
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    out_d_nxt = out_d_r;
    sk_d_nxt  = sk_d_r;
    if (pop) begin
      if (sk_v_r) begin
        out_d_nxt = sk_d_r;
        sk_v_nxt  = push;
        sk_d_nxt  = res;
      end else begin
        out_v_nxt = push;
        out_d_nxt = res;
      end
    end else if (push) begin
      if (!out_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res;
      end else begin
        sk_v_nxt = 1'b1;
        sk_d_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign out_valid              = out_v_r;
  assign out_found              = out_d_r.found;
  assign out_match_index        = out_d_r.match_index;
  assign out_position_saturated = out_d_r.position_saturated;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid word held with empty output register");

  a_one_hit_per_text: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> !push)
    else $error("second result pushed within one text");

  a_sat_pos_held: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pos_r == '1)
    else $error("position counter left its ceiling while saturated");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_v_r && !pop) |=> (sk_d_r == $past(sk_d_r)))
    else $error("skid word overwritten while held");
`endif

endmodule

`default_nettype wire
